### hdl/fgpc_pkg.sv
package fgpc_pkg;

  // Register map of the configuration channel
  typedef enum logic [2:0] {
    REG_KP_BASE       = 3'd0,
    REG_KI_BASE       = 3'd1,
    REG_KD_BASE       = 3'd2,
    REG_KP_SPAN       = 3'd3,
    REG_KI_SPAN       = 3'd4,
    REG_KD_SPAN       = 3'd5,
    REG_QUANT_SCALES  = 3'd6,
    REG_OUTPUT_LIMITS = 3'd7
  } cfg_reg_t;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;

  localparam int SampleW = 16;
  localparam int ErrW    = 17;
  localparam int ChgW    = 18;
  localparam int SmoothW = 26;
  localparam int GainW   = 20;
  localparam int ProdQW  = 35;

  // Reset values of the configuration registers
  localparam logic [15:0] KpBaseRst = 16'd256;
  localparam logic [31:0] QuantScalesRst = 32'h0100_0100;
  localparam logic [31:0] OutputLimitsRst = 32'h7FFF_8000;

  // Rule tables, row = error index, column = change index
  localparam logic signed [3:0] RULE_P [7][7] = '{
    '{4'sd6, 4'sd6, 4'sd5, 4'sd5, 4'sd4, 4'sd2, 4'sd2},
    '{4'sd6, 4'sd6, 4'sd5, 4'sd4, 4'sd4, 4'sd2, 4'sd1},
    '{4'sd5, 4'sd5, 4'sd5, 4'sd4, 4'sd2, 4'sd1, 4'sd1},
    '{4'sd5, 4'sd5, 4'sd4, 4'sd2, 4'sd1, 4'sd0, 4'sd0},
    '{4'sd4, 4'sd4, 4'sd2, 4'sd1, 4'sd1, 4'sd0, 4'sd0},
    '{4'sd4, 4'sd2, 4'sd1, 4'sd0, 4'sd0, 4'sd0, -4'sd1},
    '{4'sd2, 4'sd2, 4'sd0, 4'sd0, 4'sd0, -4'sd1, -4'sd1}
  };
  localparam logic signed [3:0] RULE_I [7][7] = '{
    '{-4'sd6, -4'sd6, -4'sd5, -4'sd5, -4'sd4, -4'sd2, -4'sd2},
    '{-4'sd6, -4'sd6, -4'sd5, -4'sd4, -4'sd4, -4'sd2, 4'sd0},
    '{-4'sd5, -4'sd5, -4'sd4, -4'sd4, -4'sd2, 4'sd0, 4'sd0},
    '{-4'sd5, -4'sd5, -4'sd4, 4'sd0, 4'sd2, 4'sd4, 4'sd5},
    '{-4'sd4, -4'sd4, -4'sd2, 4'sd0, 4'sd4, 4'sd5, 4'sd5},
    '{-4'sd2, 4'sd0, 4'sd2, 4'sd4, 4'sd5, 4'sd6, 4'sd6},
    '{4'sd0, 4'sd2, 4'sd4, 4'sd5, 4'sd6, 4'sd6, 4'sd6}
  };
  localparam logic signed [3:0] RULE_D [7][7] = '{
    '{4'sd2, 4'sd2, 4'sd1, 4'sd1, 4'sd0, -4'sd1, -4'sd2},
    '{4'sd2, 4'sd2, 4'sd1, 4'sd1, 4'sd0, -4'sd1, -4'sd2},
    '{4'sd1, 4'sd1, 4'sd1, 4'sd0, -4'sd1, -4'sd1, -4'sd2},
    '{4'sd1, 4'sd1, 4'sd0, -4'sd1, -4'sd1, -4'sd2, -4'sd2},
    '{4'sd0, 4'sd0, -4'sd1, -4'sd1, -4'sd2, -4'sd2, -4'sd4},
    '{4'sd0, -4'sd1, -4'sd1, -4'sd2, -4'sd2, -4'sd4, -4'sd4},
    '{-4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd4, -4'sd4, -4'sd6}
  };

  // Command bundle from the sequencer to the datapath
  typedef struct packed {
    logic capture;
    logic do_err;
    logic do_chg;
    logic do_qnt;
    logic do_idx;
    logic do_gain;
    logic do_mul;
    logic do_sum;
    logic do_div3;
    logic load_out;
  } fgpc_cmd_t;

  // Clamp a scaled value to -1..1 (Q8.8) and map it to an index 0..6
  function automatic logic [2:0] quant_index(input logic signed [ProdQW-1:0] p);
    logic [9:0]  pos;
    logic [11:0] tri3;
    if (p > 35'sd256) begin
      pos = 10'd512;
    end else if (p < -35'sd256) begin
      pos = 10'd0;
    end else begin
      pos = 10'(p + 35'sd256);
    end
    tri3 = 12'(pos) * 12'd3;
    return tri3[10:8];
  endfunction

  // Gain in units of 1/1536: 6*base + rule*span, floored at zero
  function automatic logic [GainW-1:0] gain_calc(input logic [15:0] base,
                                                 input logic [15:0] span,
                                                 input logic signed [3:0] rule);
    logic signed [20:0] six_base;
    logic signed [20:0] adj;
    logic signed [20:0] g;
    six_base = $signed({5'b0, base} * 21'd6);
    adj      = 21'(rule) * $signed({5'b0, span});
    g        = six_base + adj;
    return g[20] ? '0 : g[GainW-1:0];
  endfunction

endpackage

### hdl/fgpc_ctrl.sv
module fgpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output fgpc_pkg::fgpc_cmd_t cmd
);
  import fgpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_CHG, S_QNT, S_IDX, S_GAIN, S_MUL, S_SUM, S_DIV3, S_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_blocked;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = out_valid_r;
  assign out_blocked = out_valid_r && !out_tready;

  // Decode one datapath step per state
  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_tvalid;
    cmd.do_err   = (state_r == S_ERR);
    cmd.do_chg   = (state_r == S_CHG);
    cmd.do_qnt   = (state_r == S_QNT);
    cmd.do_idx   = (state_r == S_IDX);
    cmd.do_gain  = (state_r == S_GAIN);
    cmd.do_mul   = (state_r == S_MUL);
    cmd.do_sum   = (state_r == S_SUM);
    cmd.do_div3  = (state_r == S_DIV3);
    cmd.load_out = (state_r == S_OUT) && !out_blocked;
  end

  // Advance the sequence and hold the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:  if (in_tvalid) state_r <= S_ERR;
        S_ERR:   state_r <= S_CHG;
        S_CHG:   state_r <= S_QNT;
        S_QNT:   state_r <= S_IDX;
        S_IDX:   state_r <= S_GAIN;
        S_GAIN:  state_r <= S_MUL;
        S_MUL:   state_r <= S_SUM;
        S_SUM:   state_r <= S_DIV3;
        S_DIV3:  state_r <= S_OUT;
        S_OUT:   if (!out_blocked) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath step in a cycle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_blocked)
    else $error("result loaded over a pending transaction");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_ERR))
    else $error("accepted sample did not start a step");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

### hdl/fgpc_datapath.sv
module fgpc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fgpc_pkg::fgpc_cmd_t                 cmd,
  input  logic [2*fgpc_pkg::SampleW-1:0]      in_data,
  input  logic                                cfg_we,
  input  logic [fgpc_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [fgpc_pkg::CfgDataW-1:0]       cfg_data,
  output logic [fgpc_pkg::SampleW-1:0]        drive
);
  import fgpc_pkg::*;

  // Configuration registers
  logic [15:0] kp_base_r, ki_base_r, kd_base_r;
  logic [15:0] kp_span_r, ki_span_r, kd_span_r;
  logic [31:0] quant_scales_r, output_limits_r;

  // Controller state carried between samples
  logic signed [ErrW-1:0]    last_err_r;
  logic signed [ErrW-1:0]    esum_r;
  logic signed [SmoothW-1:0] sm_r;

  // Per-sample working registers
  logic signed [SampleW-1:0] tgt_r, meas_r;
  logic signed [ErrW-1:0]    err_r;
  logic signed [ChgW-1:0]    chg_r;
  logic signed [ProdQW-1:0]  pe_r, pc_r;
  logic [2:0]                ei_r, ci_r;
  logic [30:0]               num10_r;
  logic [62:0]               prod10_r;
  logic [GainW-1:0]          gp_r, gi_r, gd_r;
  logic signed [37:0]        pp_r, pi_r;
  logic signed [46:0]        pd_r;
  logic signed [17:0]        t_r;
  logic [35:0]               q3_r;
  logic [SampleW-1:0]        drive_r;

  logic signed [15:0] omin, omax;
  logic signed [16:0] lim_diff, lim;
  logic signed [17:0] acc, lim18, nlim18, acc_cl;
  logic signed [31:0] filt_x;
  logic [27:0]        q10;
  logic signed [47:0] s48, tsh;
  logic signed [17:0] t_sat;
  logic [17:0]        n3;
  logic [15:0]        q3;
  logic signed [16:0] y, y_cl;

  assign omin  = $signed(output_limits_r[15:0]);
  assign omax  = $signed(output_limits_r[31:16]);
  assign drive = drive_r;

  // Integral clamp to half the output span, upper bound first
  always_comb begin
    lim_diff = 17'(omax) - 17'(omin);
    lim      = lim_diff >>> 1;
    lim18    = 18'(lim);
    nlim18   = -lim18;
    acc      = 18'(esum_r) + 18'(err_r);
    acc_cl   = acc;
    if (acc_cl > lim18) acc_cl = lim18;
    if (acc_cl < nlim18) acc_cl = nlim18;
  end

  // Filter numerator 768*chg + 7*s + 5, biased by 10*2^26 to stay positive
  assign filt_x = 32'(chg_r) * 32'sd768 + 32'(sm_r) * 32'sd7 + 32'sd5
                + 32'sd671088640;
  // Reciprocal multiply gives floor(n/10) exactly below 2^31
  assign q10 = prod10_r[62:35];

  // Sum the terms, round, drop 2^17, saturate to the range that still clamps alike
  always_comb begin
    s48 = (48'(pp_r) <<< 8) + (48'(pi_r) <<< 8) + 48'(pd_r) + 48'sd196608;
    tsh = s48 >>> 17;
    if (tsh > 48'sd98303) begin
      t_sat = 18'sd98303;
    end else if (tsh < -48'sd98304) begin
      t_sat = -18'sd98304;
    end else begin
      t_sat = 18'(tsh);
    end
  end

  // Divide by three through a reciprocal, then clamp max first, min second
  always_comb begin
    n3   = t_r + 18'd98304;
    q3   = q3_r[34:19];
    y    = $signed({1'b0, q3}) - 17'sd32768;
    y_cl = y;
    if (y_cl > 17'(omax)) y_cl = 17'(omax);
    if (y_cl < 17'(omin)) y_cl = 17'(omin);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_base_r       <= KpBaseRst;
      ki_base_r       <= '0;
      kd_base_r       <= '0;
      kp_span_r       <= '0;
      ki_span_r       <= '0;
      kd_span_r       <= '0;
      quant_scales_r  <= QuantScalesRst;
      output_limits_r <= OutputLimitsRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP_BASE:       kp_base_r       <= cfg_data[15:0];
        REG_KI_BASE:       ki_base_r       <= cfg_data[15:0];
        REG_KD_BASE:       kd_base_r       <= cfg_data[15:0];
        REG_KP_SPAN:       kp_span_r       <= cfg_data[15:0];
        REG_KI_SPAN:       ki_span_r       <= cfg_data[15:0];
        REG_KD_SPAN:       kd_span_r       <= cfg_data[15:0];
        REG_QUANT_SCALES:  quant_scales_r  <= cfg_data;
        REG_OUTPUT_LIMITS: output_limits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      esum_r     <= '0;
      sm_r       <= '0;
    end else begin
      if (cmd.do_qnt) esum_r <= acc_cl[ErrW-1:0];
      if (cmd.do_gain) sm_r <= SmoothW'(q10 - 28'd67108864);
      if (cmd.load_out) last_err_r <= err_r;
    end
  end

  // Working registers, one step per command
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_r  <= $signed(in_data[SampleW-1:0]);
      meas_r <= $signed(in_data[2*SampleW-1:SampleW]);
    end
    if (cmd.do_err) err_r <= ErrW'(tgt_r) - ErrW'(meas_r);
    if (cmd.do_chg) begin
      chg_r <= ChgW'(err_r) - ChgW'(last_err_r);
      pe_r  <= ChgW'(err_r) * $signed({1'b0, quant_scales_r[15:0]});
    end
    if (cmd.do_qnt) begin
      pc_r    <= chg_r * $signed({1'b0, quant_scales_r[31:16]});
      ei_r    <= quant_index(pe_r);
      num10_r <= filt_x[30:0];
    end
    if (cmd.do_idx) begin
      ci_r     <= quant_index(pc_r);
      prod10_r <= 63'(num10_r) * 63'd3435973837;
    end
    if (cmd.do_gain) begin
      gp_r <= gain_calc(kp_base_r, kp_span_r, RULE_P[ei_r][ci_r]);
      gi_r <= gain_calc(ki_base_r, ki_span_r, RULE_I[ei_r][ci_r]);
      gd_r <= gain_calc(kd_base_r, kd_span_r, RULE_D[ei_r][ci_r]);
    end
    if (cmd.do_mul) begin
      pp_r <= $signed({1'b0, gp_r}) * err_r;
      pi_r <= $signed({1'b0, gi_r}) * esum_r;
      pd_r <= $signed({1'b0, gd_r}) * sm_r;
    end
    if (cmd.do_sum) t_r <= t_sat;
    if (cmd.do_div3) q3_r <= 36'(n3) * 36'd174763;
    if (cmd.load_out) drive_r <= y_cl[SampleW-1:0];
  end

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_sum |=> (t_r <= 18'sd98303) && (t_r >= -18'sd98304))
    else $error("saturated sum out of range");

endmodule

### hdl/fuzzy_gain_pid_controller_top.sv
// Channel | Dir | Handshake            | Payload
// in      | in  | in_tvalid/in_tready  | in_tdata: target, measured
// out     | out | out_tvalid/out_tready| out_tdata: drive
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A drive becomes valid after the step sequencer walks the datapath through
// its chained multiplies: error, change, quantize, index, gain, multiply,
// sum, divide-by-three and output-load, in that order. The next sample is
// taken once the sequencer is back in idle, so a new sample is not accepted
// while the last one is still in progress. A waiting drive transaction
// stalls only the final load step, and with it the next acceptance.
// Synchronous active-low reset restores register defaults and clears state.
// Configuration writes are always taken; cfg_ready is tied high.
module fuzzy_gain_pid_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*fgpc_pkg::SampleW-1:0]      in_tdata,   // target, measured
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fgpc_pkg::SampleW-1:0]        out_tdata,  // drive
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fgpc_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [fgpc_pkg::CfgDataW-1:0]       cfg_data
);
  import fgpc_pkg::*;

  fgpc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  fgpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  fgpc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .drive     (out_tdata)
  );

endmodule

### sim/tb.sv
module tb;
  import fgpc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandPhases = 9;
  localparam int PhaseItems = 150;

  // Predicts the drive for each accepted sample and holds the drives still owed
  class drive_scoreboard;
    logic [15:0] gain_base [3];
    logic [15:0] gain_span [3];
    logic [31:0] scales;
    logic [31:0] limits;
    longint      last_err;
    longint      err_sum;
    longint      smooth;
    logic [15:0] owed [$];
    int          errors;

    function new();
      gain_base = '{KpBaseRst, 16'd0, 16'd0};
      gain_span = '{16'd0, 16'd0, 16'd0};
      scales    = QuantScalesRst;
      limits    = OutputLimitsRst;
      last_err  = 0;
      err_sum   = 0;
      smooth    = 0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_KP_BASE:       gain_base[0] = d[15:0];
        REG_KI_BASE:       gain_base[1] = d[15:0];
        REG_KD_BASE:       gain_base[2] = d[15:0];
        REG_KP_SPAN:       gain_span[0] = d[15:0];
        REG_KI_SPAN:       gain_span[1] = d[15:0];
        REG_KD_SPAN:       gain_span[2] = d[15:0];
        REG_QUANT_SCALES:  scales = d;
        REG_OUTPUT_LIMITS: limits = d;
        default: ;
      endcase
    endfunction

    function longint fdiv(longint x, longint d);
      longint q;
      q = x / d;
      if ((x % d) != 0 && x < 0) q--;
      return q;
    endfunction

    // Scale, clamp to -1..1 and map to a rule index
    function int level(longint x, longint scale);
      longint p;
      longint q;
      p = x * scale;
      if (p > 256) p = 256;
      if (p < -256) p = -256;
      q = ((p + 256) * 3) >>> 8;
      return (q > 6) ? 6 : int'(q);
    endfunction

    function longint gain6(int k, int rule);
      longint g;
      g = 6 * longint'(gain_base[k]) + longint'(rule) * longint'(gain_span[k]);
      return (g < 0) ? 0 : g;
    endfunction

    function void note_sample(logic signed [15:0] tgt, logic signed [15:0] meas);
      longint err, chg, omin, omax, lim, acc, gp, gi, gd, total, y;
      int ei, ci;
      err  = longint'(tgt) - longint'(meas);
      chg  = err - last_err;
      omin = longint'($signed(limits[15:0]));
      omax = longint'($signed(limits[31:16]));
      ei = level(err, longint'(scales[15:0]));
      ci = level(chg, longint'(scales[31:16]));
      gp = gain6(0, int'(RULE_P[ei][ci]));
      gi = gain6(1, int'(RULE_I[ei][ci]));
      gd = gain6(2, int'(RULE_D[ei][ci]));
      // Clamp the integral to half the output span
      lim = fdiv(omax - omin, 2);
      acc = err_sum + err;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      err_sum = acc;
      // Smooth the change term, alpha 0.3, round half up
      smooth = fdiv(3 * chg * 256 + 7 * smooth + 5, 10);
      total = gp * err * 256 + gi * err_sum * 256 + gd * smooth;
      y = fdiv(total + 196608, 393216);
      if (y > omax) y = omax;
      if (y < omin) y = omin;
      last_err = err;
      owed.push_back(y[15:0]);
    endfunction

    function void check_drive(logic [15:0] got);
      logic [15:0] want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected drive transaction, expected none, actual %0d",
                 $time, $signed(got));
        errors++;
        return;
      end
      want = owed.pop_front();
      if (want !== got) begin
        $display("%0t: drive mismatch, expected %0d, actual %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  drive_scoreboard sb;
  bit  no_idle;
  int  cycles;

  fuzzy_gain_pid_controller_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check every drive transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_drive(out_tdata);
  end

  // Stall the result side at random before each drive, never when no_idle is set
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // Write one register, then drop cfg_valid and leave the channel idle
  task automatic write_cfg(cfg_reg_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [15:0] tgt, logic [15:0] meas);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(tgt, meas);
  endtask

  // Hold off until every owed drive is back and the sequencer is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_limits();
    logic [15:0] lo, hi;
    case ($urandom_range(0, 4))
      0: return OutputLimitsRst;
      1: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
        return {hi, lo};
      end
      2: return {16'h8000, 16'h7FFF};
      default: begin
        lo = 16'(-$urandom_range(0, 4000));
        hi = 16'($urandom_range(0, 4000));
        return {hi, lo};
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic random_config();
    write_cfg(REG_KP_BASE, {16'($urandom), pick16()});
    write_cfg(REG_KI_BASE, {16'($urandom), pick16()});
    write_cfg(REG_KD_BASE, {16'($urandom), pick16()});
    write_cfg(REG_KP_SPAN, {16'($urandom), pick16()});
    write_cfg(REG_KI_SPAN, {16'($urandom), pick16()});
    write_cfg(REG_KD_SPAN, {16'($urandom), pick16()});
    write_cfg(REG_QUANT_SCALES, {pick_scale(), pick_scale()});
    write_cfg(REG_OUTPUT_LIMITS, pick_limits());
  endtask

  initial begin
    logic [15:0] tgt, meas;
    sb         = new();
    cycles     = 0;
    no_idle    = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset gains, field extremes
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'hFFFF, 16'h0001);
    drain();

    // Directed: all gains active, fine quantization, narrow odd span
    write_cfg(REG_KP_BASE, 32'h0000_0200);
    write_cfg(REG_KI_BASE, 32'h0000_0040);
    write_cfg(REG_KD_BASE, 32'h0000_0080);
    write_cfg(REG_KP_SPAN, 32'h0000_0100);
    write_cfg(REG_KI_SPAN, 32'h0000_0100);
    write_cfg(REG_KD_SPAN, 32'h0000_FFFF);
    write_cfg(REG_QUANT_SCALES, {16'd8, 16'd4});
    write_cfg(REG_OUTPUT_LIMITS, {16'd1001, 16'hFC18});
    for (int k = -60; k <= 60; k += 12) send_sample(16'(k), 16'(-k / 2));
    drain();

    // Directed: crossed limits and zero scales
    write_cfg(REG_QUANT_SCALES, 32'h0000_0000);
    write_cfg(REG_OUTPUT_LIMITS, {16'hFF00, 16'h0100});
    send_sample(16'h7FFF, 16'h0000);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h0010, 16'h0020);
    drain();

    // Random phases, each under a fresh setting; the last with no idling
    for (int ph = 0; ph < RandPhases; ph++) begin
      random_config();
      no_idle = (ph == RandPhases - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          tgt  = 16'($urandom);
          meas = 16'($urandom);
        end else begin
          tgt  = 16'($signed(16'($urandom_range(0, 800))) - 16'sd400);
          meas = tgt - 16'($urandom_range(0, 80)) + 16'd40;
        end
        send_sample(tgt, meas);
      end
      drain();
    end

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### fuzzy_gain_pid_controller_top.f
hdl/fgpc_pkg.sv
hdl/fgpc_ctrl.sv
hdl/fgpc_datapath.sv
hdl/fuzzy_gain_pid_controller_top.sv
sim/tb.sv
